// ----- hw/rtl/tmhq_pkg.sv -----
// tmhq_pkg: shared types, codes and sizes for the timer min-heap queue
// used by tmhq_ctrl, tmhq_dp and timer_min_heap_queue_core
package tmhq_pkg;

	localparam int unsigned HEAP_DEPTH_DEF = 64;
	localparam int unsigned MAX_RESULTS    = 64;
	localparam int unsigned KW             = $clog2(MAX_RESULTS + 1);
	localparam int unsigned DLW            = 48;
	localparam int unsigned IDW            = 32;
	localparam int unsigned TGW            = 32;
	localparam int unsigned WW             = 32;
	localparam logic [WW-1:0] WAIT_MAX     = 32'h7FFF_FFFF;
	localparam logic [IDW-1:0] ID_FIRST    = 32'd1;
	localparam logic [IDW-1:0] ID_LAST     = 32'hFFFF_FFFF;

	localparam logic [1:0] OP_SCHEDULE = 2'd0;
	localparam logic [1:0] OP_CANCEL   = 2'd1;
	localparam logic [1:0] OP_EXPIRE   = 2'd2;
	localparam logic [1:0] OP_QUERY    = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FIRED     = 3'd3;
	localparam logic [2:0] ST_NONE_DUE  = 3'd4;

	typedef struct packed {
		logic [1:0]            operation;
		logic [DLW-1:0]        now_time;
		logic [DLW-1:0]        delay;
		logic [IDW-1:0]        cancel_id;
		logic [TGW-1:0]        tag;
		logic signed [WW-1:0]  requested_wait;
	} in_word_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [IDW-1:0]        result_id;
		logic [TGW-1:0]        result_tag;
		logic signed [WW-1:0]  wait_ms;
		logic                  last;
	} out_word_t;

	typedef struct packed {
		logic            cancelled;
		logic [IDW-1:0]  id;
		logic [TGW-1:0]  tag;
		logic [DLW-1:0]  deadline;
	} entry_t;

	typedef enum logic [4:0] {
		CMD_NOP, CMD_LOAD, CMD_SCH_INIT, CMD_UP_READ, CMD_UP_STEP, CMD_PLACE,
		CMD_EMIT_SCH, CMD_EMIT_FULL, CMD_SC_READ, CMD_SC_CHECK, CMD_EMIT_OK,
		CMD_EMIT_NF, CMD_RT_READ, CMD_POP, CMD_POP_X, CMD_DN_RL, CMD_DN_RR,
		CMD_DN_CMP, CMD_EX_FIRE, CMD_EX_END, CMD_Q_ANS
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic count_zero;
		logic idx_zero;
		logic up_stop;
		logic scan_end;
		logic match;
		logic due;
		logic root_canc;
		logic left_valid;
		logic dn_stop;
		logic fire_canc;
		logic k_max;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_UP, S_UP_CHK, S_SCH_EMIT, S_SC_RD, S_SC_CHK, S_SC_OK,
		S_EX_TOP, S_EX_CHK, S_EX_FIRE, S_POP_X, S_DN_RL, S_DN_RR, S_DN_CMP,
		S_Q_TOP, S_Q_CHK
	} ctl_state_t;

endpackage

// ----- hw/rtl/tmhq_dp.sv -----
// tmhq_dp: heap memory, index and count registers, result register
// executes one tmhq_pkg::dp_cmd_t per cycle and reports tmhq_pkg::dp_stat_t
module tmhq_dp #(
	parameter int unsigned HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tmhq_pkg::in_word_t   item,
	input  tmhq_pkg::dp_cmd_t    cmd,
	output tmhq_pkg::dp_stat_t   stat,
	output tmhq_pkg::out_word_t  result,
	output logic                 result_valid
);
	localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
	localparam int unsigned EW = CW + 1;
	localparam int unsigned IDW_L = tmhq_pkg::IDW;

	tmhq_pkg::entry_t mem [HEAP_DEPTH];
	tmhq_pkg::entry_t rd_q, x_q, lft_q, fire_q, pend_q, wr_data;
	tmhq_pkg::in_word_t item_q;
	tmhq_pkg::out_word_t res_q;
	logic [CW-1:0] count_q, idx_q, parent, bidx;
	logic [IDW_L-1:0] next_id_q;
	logic [tmhq_pkg::KW-1:0] k_q;
	logic pend_valid_q, res_valid_q;
	logic [EW-1:0] lext, rext, cnt_ext;
	logic r_valid, use_r;
	tmhq_pkg::entry_t best;
	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [tmhq_pkg::DLW:0] dl_sum;
	logic [tmhq_pkg::DLW-1:0] dl_new, until48;
	logic [tmhq_pkg::WW-1:0] until32, answer, req;

	assign parent  = CW'((idx_q - CW'(1)) >> 1);
	assign lext    = {idx_q, 1'b1};
	assign rext    = lext + EW'(1);
	assign cnt_ext = EW'(count_q);
	assign r_valid = rext < cnt_ext;
	assign use_r   = r_valid && (rd_q.deadline < lft_q.deadline);
	assign best    = use_r ? rd_q : lft_q;
	assign bidx    = use_r ? CW'(rext) : CW'(lext);

	assign stat.full       = count_q >= CW'(HEAP_DEPTH);
	assign stat.count_zero = count_q == '0;
	assign stat.idx_zero   = idx_q == '0;
	assign stat.up_stop    = rd_q.deadline <= x_q.deadline;
	assign stat.scan_end   = idx_q >= count_q;
	assign stat.match      = (rd_q.id == item_q.cancel_id) && !rd_q.cancelled;
	assign stat.due        = rd_q.deadline <= item_q.now_time;
	assign stat.root_canc  = rd_q.cancelled;
	assign stat.left_valid = lext < cnt_ext;
	assign stat.dn_stop    = !(best.deadline < x_q.deadline);
	assign stat.fire_canc  = fire_q.cancelled;
	assign stat.k_max      = k_q == tmhq_pkg::KW'(tmhq_pkg::MAX_RESULTS);

	assign dl_sum = {1'b0, item_q.now_time} + {1'b0, item_q.delay};
	assign dl_new = dl_sum[tmhq_pkg::DLW] ? '1 : dl_sum[tmhq_pkg::DLW-1:0];

	// query answer from the root in rd_q
	assign req     = item_q.requested_wait;
	assign until48 = (rd_q.deadline <= item_q.now_time) ? '0
		: rd_q.deadline - item_q.now_time;
	assign until32 = (until48 > tmhq_pkg::DLW'(tmhq_pkg::WAIT_MAX)) ? tmhq_pkg::WAIT_MAX
		: until48[tmhq_pkg::WW-1:0];
	always_comb begin
		if (count_q == '0) begin
			answer = req[tmhq_pkg::WW-1] ? '1 : req;
		end else if (req[tmhq_pkg::WW-1]) begin
			answer = until32;
		end else begin
			answer = (until32 < req) ? until32 : req;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = x_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (cmd)
			tmhq_pkg::CMD_PLACE: wr_en = 1'b1;
			tmhq_pkg::CMD_UP_STEP: begin
				wr_en   = 1'b1;
				wr_data = stat.up_stop ? x_q : rd_q;
			end
			tmhq_pkg::CMD_SC_CHECK: begin
				wr_en             = stat.match;
				wr_data           = rd_q;
				wr_data.cancelled = 1'b1;
			end
			tmhq_pkg::CMD_DN_CMP: begin
				wr_en   = 1'b1;
				wr_data = stat.dn_stop ? x_q : best;
			end
			tmhq_pkg::CMD_UP_READ: begin
				rd_en   = 1'b1;
				rd_addr = parent[AW-1:0];
			end
			tmhq_pkg::CMD_SC_READ: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[AW-1:0];
			end
			tmhq_pkg::CMD_RT_READ: rd_en = 1'b1;
			tmhq_pkg::CMD_POP: begin
				rd_en   = 1'b1;
				rd_addr = AW'(count_q - CW'(1));
			end
			tmhq_pkg::CMD_DN_RL: begin
				rd_en   = 1'b1;
				rd_addr = AW'(lext);
			end
			tmhq_pkg::CMD_DN_RR: begin
				rd_en   = r_valid;
				rd_addr = AW'(rext);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			next_id_q    <= tmhq_pkg::ID_FIRST;
			k_q          <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (cmd)
				tmhq_pkg::CMD_LOAD: begin
					k_q          <= '0;
					pend_valid_q <= 1'b0;
				end
				tmhq_pkg::CMD_SCH_INIT: count_q <= count_q + CW'(1);
				tmhq_pkg::CMD_POP: count_q <= count_q - CW'(1);
				tmhq_pkg::CMD_EMIT_SCH: begin
					res_valid_q <= 1'b1;
					next_id_q   <= (next_id_q == tmhq_pkg::ID_LAST) ? tmhq_pkg::ID_FIRST
						: next_id_q + IDW_L'(1);
				end
				tmhq_pkg::CMD_EMIT_FULL, tmhq_pkg::CMD_EMIT_OK, tmhq_pkg::CMD_EMIT_NF,
				tmhq_pkg::CMD_EX_END, tmhq_pkg::CMD_Q_ANS: res_valid_q <= 1'b1;
				tmhq_pkg::CMD_EX_FIRE: begin
					if (!fire_q.cancelled) begin
						res_valid_q  <= pend_valid_q;
						pend_valid_q <= 1'b1;
						k_q          <= k_q + tmhq_pkg::KW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			tmhq_pkg::CMD_LOAD: begin
				item_q <= item;
				idx_q  <= '0;
			end
			tmhq_pkg::CMD_SCH_INIT: begin
				x_q.cancelled <= 1'b0;
				x_q.id        <= next_id_q;
				x_q.tag       <= item_q.tag;
				x_q.deadline  <= dl_new;
				idx_q         <= count_q;
			end
			tmhq_pkg::CMD_UP_STEP: if (!stat.up_stop) idx_q <= parent;
			tmhq_pkg::CMD_SC_CHECK: if (!stat.match) idx_q <= idx_q + CW'(1);
			tmhq_pkg::CMD_POP: fire_q <= rd_q;
			tmhq_pkg::CMD_POP_X: begin
				x_q   <= rd_q;
				idx_q <= '0;
			end
			tmhq_pkg::CMD_DN_RR: lft_q <= rd_q;
			tmhq_pkg::CMD_DN_CMP: if (!stat.dn_stop) idx_q <= bidx;
			tmhq_pkg::CMD_EMIT_SCH:
				res_q <= '{tmhq_pkg::ST_OK, next_id_q, '0, '0, 1'b1};
			tmhq_pkg::CMD_EMIT_FULL:
				res_q <= '{tmhq_pkg::ST_FULL, '0, '0, '0, 1'b1};
			tmhq_pkg::CMD_EMIT_OK:
				res_q <= '{tmhq_pkg::ST_OK, '0, '0, '0, 1'b1};
			tmhq_pkg::CMD_EMIT_NF:
				res_q <= '{tmhq_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1};
			tmhq_pkg::CMD_EX_FIRE: begin
				if (!fire_q.cancelled) begin
					res_q  <= '{tmhq_pkg::ST_FIRED, pend_q.id, pend_q.tag, '0, 1'b0};
					pend_q <= fire_q;
				end
			end
			tmhq_pkg::CMD_EX_END: begin
				if (pend_valid_q) begin
					res_q <= '{tmhq_pkg::ST_FIRED, pend_q.id, pend_q.tag, '0, 1'b1};
				end else begin
					res_q <= '{tmhq_pkg::ST_NONE_DUE, '0, '0, '0, 1'b1};
				end
			end
			tmhq_pkg::CMD_Q_ANS:
				res_q <= '{tmhq_pkg::ST_OK, '0, '0, answer, 1'b1};
			default: ;
		endcase
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

// ----- hw/rtl/tmhq_ctrl.sv -----
// tmhq_ctrl: sequencer for schedule, cancel, expire and query
// drives tmhq_pkg::dp_cmd_t into tmhq_dp and reads back tmhq_pkg::dp_stat_t
module tmhq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          operation,
	input  tmhq_pkg::dp_stat_t  stat,
	output tmhq_pkg::dp_cmd_t   cmd,
	output logic                busy
);
	tmhq_pkg::ctl_state_t state_q, state_nx, after_pop;
	logic [1:0] op_q;

	assign after_pop = (op_q == tmhq_pkg::OP_EXPIRE) ? tmhq_pkg::S_EX_FIRE
		: tmhq_pkg::S_Q_TOP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmhq_pkg::S_IDLE;
			op_q    <= tmhq_pkg::OP_SCHEDULE;
		end else begin
			state_q <= state_nx;
			if (state_q == tmhq_pkg::S_IDLE && start) begin
				op_q <= operation;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tmhq_pkg::S_IDLE: if (start) state_nx = tmhq_pkg::S_DISPATCH;
			tmhq_pkg::S_DISPATCH: begin
				unique case (op_q)
					tmhq_pkg::OP_SCHEDULE:
						state_nx = stat.full ? tmhq_pkg::S_IDLE : tmhq_pkg::S_UP;
					tmhq_pkg::OP_CANCEL: state_nx = tmhq_pkg::S_SC_RD;
					tmhq_pkg::OP_EXPIRE: state_nx = tmhq_pkg::S_EX_TOP;
					default: state_nx = tmhq_pkg::S_Q_TOP;
				endcase
			end
			tmhq_pkg::S_UP:
				state_nx = stat.idx_zero ? tmhq_pkg::S_SCH_EMIT : tmhq_pkg::S_UP_CHK;
			tmhq_pkg::S_UP_CHK:
				state_nx = stat.up_stop ? tmhq_pkg::S_SCH_EMIT : tmhq_pkg::S_UP;
			tmhq_pkg::S_SCH_EMIT: state_nx = tmhq_pkg::S_IDLE;
			tmhq_pkg::S_SC_RD:
				state_nx = stat.scan_end ? tmhq_pkg::S_IDLE : tmhq_pkg::S_SC_CHK;
			tmhq_pkg::S_SC_CHK:
				state_nx = stat.match ? tmhq_pkg::S_SC_OK : tmhq_pkg::S_SC_RD;
			tmhq_pkg::S_SC_OK: state_nx = tmhq_pkg::S_IDLE;
			tmhq_pkg::S_EX_TOP:
				state_nx = (stat.count_zero || stat.k_max) ? tmhq_pkg::S_IDLE
					: tmhq_pkg::S_EX_CHK;
			tmhq_pkg::S_EX_CHK:
				state_nx = stat.due ? tmhq_pkg::S_POP_X : tmhq_pkg::S_IDLE;
			tmhq_pkg::S_EX_FIRE: state_nx = tmhq_pkg::S_EX_TOP;
			tmhq_pkg::S_POP_X:
				state_nx = stat.count_zero ? after_pop : tmhq_pkg::S_DN_RL;
			tmhq_pkg::S_DN_RL:
				state_nx = stat.left_valid ? tmhq_pkg::S_DN_RR : after_pop;
			tmhq_pkg::S_DN_RR: state_nx = tmhq_pkg::S_DN_CMP;
			tmhq_pkg::S_DN_CMP:
				state_nx = stat.dn_stop ? after_pop : tmhq_pkg::S_DN_RL;
			tmhq_pkg::S_Q_TOP:
				state_nx = stat.count_zero ? tmhq_pkg::S_IDLE : tmhq_pkg::S_Q_CHK;
			tmhq_pkg::S_Q_CHK:
				state_nx = stat.root_canc ? tmhq_pkg::S_POP_X : tmhq_pkg::S_IDLE;
			default: state_nx = tmhq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = tmhq_pkg::CMD_NOP;
		unique case (state_q)
			tmhq_pkg::S_IDLE: if (start) cmd = tmhq_pkg::CMD_LOAD;
			tmhq_pkg::S_DISPATCH: begin
				if (op_q == tmhq_pkg::OP_SCHEDULE) begin
					cmd = stat.full ? tmhq_pkg::CMD_EMIT_FULL : tmhq_pkg::CMD_SCH_INIT;
				end
			end
			tmhq_pkg::S_UP:
				cmd = stat.idx_zero ? tmhq_pkg::CMD_PLACE : tmhq_pkg::CMD_UP_READ;
			tmhq_pkg::S_UP_CHK: cmd = tmhq_pkg::CMD_UP_STEP;
			tmhq_pkg::S_SCH_EMIT: cmd = tmhq_pkg::CMD_EMIT_SCH;
			tmhq_pkg::S_SC_RD:
				cmd = stat.scan_end ? tmhq_pkg::CMD_EMIT_NF : tmhq_pkg::CMD_SC_READ;
			tmhq_pkg::S_SC_CHK: cmd = tmhq_pkg::CMD_SC_CHECK;
			tmhq_pkg::S_SC_OK: cmd = tmhq_pkg::CMD_EMIT_OK;
			tmhq_pkg::S_EX_TOP:
				cmd = (stat.count_zero || stat.k_max) ? tmhq_pkg::CMD_EX_END
					: tmhq_pkg::CMD_RT_READ;
			tmhq_pkg::S_EX_CHK: cmd = stat.due ? tmhq_pkg::CMD_POP : tmhq_pkg::CMD_EX_END;
			tmhq_pkg::S_EX_FIRE: cmd = tmhq_pkg::CMD_EX_FIRE;
			tmhq_pkg::S_POP_X: if (!stat.count_zero) cmd = tmhq_pkg::CMD_POP_X;
			tmhq_pkg::S_DN_RL:
				cmd = stat.left_valid ? tmhq_pkg::CMD_DN_RL : tmhq_pkg::CMD_PLACE;
			tmhq_pkg::S_DN_RR: cmd = tmhq_pkg::CMD_DN_RR;
			tmhq_pkg::S_DN_CMP: cmd = tmhq_pkg::CMD_DN_CMP;
			tmhq_pkg::S_Q_TOP:
				cmd = stat.count_zero ? tmhq_pkg::CMD_Q_ANS : tmhq_pkg::CMD_RT_READ;
			tmhq_pkg::S_Q_CHK:
				cmd = stat.root_canc ? tmhq_pkg::CMD_POP : tmhq_pkg::CMD_Q_ANS;
			default: cmd = tmhq_pkg::CMD_NOP;
		endcase
	end

	assign busy = state_q != tmhq_pkg::S_IDLE;

endmodule

// ----- hw/rtl/timer_min_heap_queue_core.sv -----
// timer_min_heap_queue_core: top level of the timer min-heap queue
// instantiates tmhq_ctrl and tmhq_dp, types from tmhq_pkg
//
// A word is taken when start is high and busy is low; results come out one per
// strobe on result_valid, with result.last on the final one, and must be taken
// in that cycle since the block cannot be held off. The heap sits in a single
// memory with one read and one write port and a registered read, so every heap
// step waits on its read: schedule climbs the heap one level per step, cancel
// scans the entries in order, a query first pops each cancelled root, and
// expire pops each due entry, firing those not cancelled. No clearing pass after reset.
module timer_min_heap_queue_core #(
	parameter int unsigned HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tmhq_pkg::in_word_t   item,
	output tmhq_pkg::out_word_t  result,
	output logic                 result_valid
);
	tmhq_pkg::dp_cmd_t  cmd;
	tmhq_pkg::dp_stat_t stat;

	tmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	tmhq_dp #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy) else $error("busy after final word");
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy) else $error("idle before final word");
	a_more_fired: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.status == tmhq_pkg::ST_FIRED)
		else $error("non-final word that is not a fired timer");

endmodule

// ----- test/testbench.sv -----
// testbench: checks timer_min_heap_queue_core against a software min-heap predictor
// depends on tmhq_pkg and timer_min_heap_queue_core
module testbench;
	import tmhq_pkg::*;

	localparam int unsigned DEPTH = HEAP_DEPTH_DEF;
	localparam logic [DLW-1:0] DL_MAX = {DLW{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_word_t item = '0;
	out_word_t result;
	logic result_valid;

	timer_min_heap_queue_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .result(result), .result_valid(result_valid)
	);

	always #5 clk = ~clk;

	// predictor state
	entry_t heap[DEPTH];
	int unsigned heap_count;
	logic [IDW-1:0] id_next;
	out_word_t expected_words[$];
	int fail_count = 0;
	bit idle_ok = 1'b1;
	logic [IDW-1:0] issued_ids[$];

	function automatic out_word_t mk_word(logic [2:0] st, logic [IDW-1:0] id,
			logic [TGW-1:0] tg, logic [WW-1:0] w, logic lst);
		out_word_t o;
		o.status = st; o.result_id = id; o.result_tag = tg; o.wait_ms = w; o.last = lst;
		return o;
	endfunction

	task automatic sift_down_heap(int unsigned i);
		int unsigned l, r, s;
		entry_t t;
		forever begin
			l = 2 * i + 1; r = 2 * i + 2; s = i;
			if (l < heap_count && heap[l].deadline < heap[s].deadline) s = l;
			if (r < heap_count && heap[r].deadline < heap[s].deadline) s = r;
			if (s == i) return;
			t = heap[i]; heap[i] = heap[s]; heap[s] = t;
			i = s;
		end
	endtask

	task automatic pop_heap_root();
		if (heap_count == 0) return;
		heap_count--;
		if (heap_count > 0) begin
			heap[0] = heap[heap_count];
			sift_down_heap(0);
		end
	endtask

	task automatic predict_timer_words(in_word_t w);
		logic [DLW:0] sum;
		logic [DLW-1:0] wait_lim;
		int unsigned i, p, k;
		entry_t t;
		bit found;
		case (w.operation)
			OP_SCHEDULE: begin
				if (heap_count >= DEPTH) begin
					expected_words.push_back(mk_word(ST_FULL, '0, '0, '0, 1'b1));
				end else begin
					sum = w.now_time + w.delay;
					t.deadline = sum[DLW] ? DL_MAX : sum[DLW-1:0];
					t.id = id_next; t.tag = w.tag; t.cancelled = 1'b0;
					i = heap_count; heap[i] = t; heap_count++;
					while (i > 0) begin
						p = (i - 1) / 2;
						if (heap[p].deadline <= heap[i].deadline) break;
						t = heap[p]; heap[p] = heap[i]; heap[i] = t;
						i = p;
					end
					expected_words.push_back(mk_word(ST_OK, id_next, '0, '0, 1'b1));
					issued_ids.push_back(id_next);
					id_next = (id_next == ID_LAST) ? ID_FIRST : id_next + 1;
				end
			end
			OP_CANCEL: begin
				found = 1'b0;
				for (i = 0; i < heap_count && !found; i++)
					if (heap[i].id == w.cancel_id && !heap[i].cancelled) begin
						heap[i].cancelled = 1'b1; found = 1'b1;
					end
				expected_words.push_back(mk_word(found ? ST_OK : ST_NOT_FOUND,
					'0, '0, '0, 1'b1));
			end
			OP_EXPIRE: begin
				k = 0;
				while (heap_count > 0 && heap[0].deadline <= w.now_time && k < MAX_RESULTS) begin
					t = heap[0];
					pop_heap_root();
					if (t.cancelled) continue;
					expected_words.push_back(mk_word(ST_FIRED, t.id, t.tag, '0, 1'b0));
					k++;
				end
				if (k == 0) expected_words.push_back(mk_word(ST_NONE_DUE, '0, '0, '0, 1'b1));
				else expected_words[$].last = 1'b1;
			end
			default: begin
				while (heap_count > 0 && heap[0].cancelled) pop_heap_root();
				if (heap_count == 0) begin
					expected_words.push_back(mk_word(ST_OK, '0, '0,
						w.requested_wait[WW-1] ? '1 : w.requested_wait, 1'b1));
				end else begin
					wait_lim = (heap[0].deadline <= w.now_time) ? '0
						: heap[0].deadline - w.now_time;
					if (wait_lim > WAIT_MAX) wait_lim = WAIT_MAX;
					if (!w.requested_wait[WW-1] && w.requested_wait < wait_lim)
						wait_lim = w.requested_wait;
					expected_words.push_back(mk_word(ST_OK, '0, '0, wait_lim[WW-1:0], 1'b1));
				end
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		fail_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && result_valid) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", result, '0);
			end else begin
				e = expected_words.pop_front();
				if (result.status !== e.status) report_mismatch("status", result.status, e.status);
				if (result.result_id !== e.result_id)
					report_mismatch("result_id", result.result_id, e.result_id);
				if (result.result_tag !== e.result_tag)
					report_mismatch("result_tag", result.result_tag, e.result_tag);
				if (result.wait_ms !== e.wait_ms)
					report_mismatch("wait_ms", result.wait_ms, e.wait_ms);
				if (result.last !== e.last) report_mismatch("last", result.last, e.last);
			end
		end
	end

	// start stays high between back-to-back words and drops only while idling
	task automatic send_word(in_word_t w);
		if (idle_ok && $urandom_range(99) < 13) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 13);
		end
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_timer_words(w);
	endtask

	function automatic in_word_t mk_item(logic [1:0] op, logic [DLW-1:0] now,
			logic [DLW-1:0] dly, logic [IDW-1:0] cid, logic [TGW-1:0] tg, logic [WW-1:0] req);
		in_word_t w;
		w.operation = op; w.now_time = now; w.delay = dly; w.cancel_id = cid;
		w.tag = tg; w.requested_wait = req;
		return w;
	endfunction

	function automatic logic [47:0] rand48();
		return {$urandom(), $urandom()};
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		send_word(mk_item(OP_QUERY, 0, 0, 0, 0, -1));
		send_word(mk_item(OP_QUERY, 0, 0, 0, 0, 32'h7FFF_FFFF));
		send_word(mk_item(OP_EXPIRE, DL_MAX, 0, 0, 0, 0));
		send_word(mk_item(OP_CANCEL, 0, 0, 0, 0, 0));
		send_word(mk_item(OP_SCHEDULE, DL_MAX, DL_MAX, 0, '1, '1));
		send_word(mk_item(OP_SCHEDULE, 100, 0, '1, 32'h1234, 0));
		send_word(mk_item(OP_SCHEDULE, 100, 50, 0, 32'h55, 0));
		send_word(mk_item(OP_SCHEDULE, 0, 150, 0, 32'h66, 0));
		send_word(mk_item(OP_QUERY, 10, 0, 0, 0, -1));
		send_word(mk_item(OP_QUERY, 10, 0, 0, 0, 5));
		send_word(mk_item(OP_QUERY, 0, 0, 0, 0, 32'h8000_0000));
		send_word(mk_item(OP_CANCEL, 0, 0, 2, 0, 0));
		send_word(mk_item(OP_CANCEL, 0, 0, 2, 0, 0));
		send_word(mk_item(OP_QUERY, 200, 0, 0, 0, 0));
		send_word(mk_item(OP_EXPIRE, 150, 0, 0, 0, 0));
		send_word(mk_item(OP_QUERY, 0, 0, 0, 0, -1));
		send_word(mk_item(OP_CANCEL, 0, 0, 1, 0, 0));
		send_word(mk_item(OP_QUERY, 0, 0, 0, 0, 7));
	endtask

	task automatic test_full_and_burst();
		// fill to capacity, one more is rejected, cancel one, then drain with two expires
		idle_ok = 1'b0;
		while (heap_count < DEPTH)
			send_word(mk_item(OP_SCHEDULE, 1000, $urandom_range(200), 0, $urandom(), 0));
		send_word(mk_item(OP_SCHEDULE, 0, 0, 0, 0, 0));
		idle_ok = 1'b1;
		send_word(mk_item(OP_CANCEL, 0, 0, issued_ids[$ - 3], 0, 0));
		send_word(mk_item(OP_EXPIRE, 1100, 0, 0, 0, 0));
		send_word(mk_item(OP_EXPIRE, DL_MAX - 1, 0, 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_random();
		in_word_t w;
		logic [DLW-1:0] base;
		int n;
		base = 5000;
		for (n = 0; n < 35; n++) begin
			w = mk_item($urandom_range(3), base + $urandom_range(300), $urandom_range(400),
				$urandom(), $urandom(), $urandom_range(500));
			if ($urandom_range(9) == 0) begin
				w.now_time = rand48(); w.delay = rand48(); w.requested_wait = $urandom();
			end
			if ($urandom_range(4) != 0 && issued_ids.size() > 0)
				w.cancel_id = issued_ids[$urandom_range(issued_ids.size() - 1)];
			if ($urandom_range(3) == 0) w.requested_wait = -1;
			if (w.operation == OP_EXPIRE) base += $urandom_range(200);
			send_word(w);
			if (n == 17) wait_drained();
		end
		send_word(mk_item(OP_EXPIRE, DL_MAX, 0, 0, 0, 0));
	endtask

	initial begin
		heap_count = 0;
		id_next = ID_FIRST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_and_burst();
		test_random();
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0 && expected_words.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/tmhq_pkg.sv
hw/rtl/tmhq_dp.sv
hw/rtl/tmhq_ctrl.sv
hw/rtl/timer_min_heap_queue_core.sv
test/testbench.sv
